// File: design/edmt_pkg.sv
// edmt_pkg: shared types and constants for the egg drop minimum-trials block
// no dependencies; imported by the step unit and the top level

package edmt_pkg;

  // result field width and the all-ones running-minimum sentinel
  localparam int OUT_W = 9;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // input field widths
  localparam int EGGS_IN_W   = 5;
  localparam int FLOORS_IN_W = 9;

  // control from the sequencer to the shared min/max unit
  typedef struct packed {
    logic clear;  // reload the running minimum with the sentinel
    logic en;     // fold one pair of table reads into the minimum
  } edmt_step_ctl_t;

endpackage

// File: design/edmt_if.sv
// edmt_if: valid/ready channel interfaces for the egg drop block
// depends on edmt_pkg for field widths

interface edmt_in_if;
  import edmt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [EGGS_IN_W-1:0]   eggs;
  logic [FLOORS_IN_W-1:0] floors;

  modport source (output valid, output eggs, output floors, input ready);
  modport sink   (input valid, input eggs, input floors, output ready);
endinterface

interface edmt_out_if;
  import edmt_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] min_trials;

  modport source (output valid, output min_trials, input ready);
  modport sink   (input valid, input min_trials, output ready);
endinterface

// File: design/edmt_ram.sv
// edmt_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module edmt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/edmt_step_unit.sv
// edmt_step_unit: shared max/increment/min unit holding the running minimum
// depends on edmt_pkg for the control struct and the sentinel

module edmt_step_unit #(
  parameter int ENTRY_W = 9
) (
  input  logic                    clk,
  input  edmt_pkg::edmt_step_ctl_t ctl,
  input  logic [ENTRY_W-1:0]      broke,
  input  logic [ENTRY_W-1:0]      held,
  output logic [ENTRY_W-1:0]      best
);
  import edmt_pkg::*;

  logic [ENTRY_W-1:0] worst;
  logic [ENTRY_W:0]   worst_inc;
  logic [ENTRY_W-1:0] best_r;

  // worst case of one drop position, plus the drop itself
  assign worst     = (broke > held) ? broke : held;
  assign worst_inc = {1'b0, worst} + {{ENTRY_W{1'b0}}, 1'b1};

  // running minimum over drop positions
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_r <= ENTRY_W'(OUT_MAX);
    end else if (ctl.en && (worst_inc < {1'b0, best_r})) begin
      best_r <= worst_inc[ENTRY_W-1:0];
    end
  end

  assign best = best_r;

endmodule

// File: design/egg_drop_min_trials.sv
// egg_drop_min_trials: top level, sequencer plus two row banks and the step unit
// depends on edmt_pkg, edmt_if, edmt_ram and edmt_step_unit
//
// Usage: in_chan carries one transaction per problem (eggs, floors); out_chan
// returns one min_trials value for each. Both are valid/ready channels.
// Egg and floor counts above MAX_EGGS / MAX_FLOORS saturate to those values;
// answers above 511 saturate to 511. Zero floors answers 0, zero eggs 511.
// Zero floors, zero eggs or one egg go straight to the done state and the
// output register. Otherwise the sequencer writes the one-egg row into bank
// 0, then for each further egg row clears column 0 and, for each floor f,
// makes one read a cycle from each row bank into the shared max/min unit,
// one per drop position, then a drain step and a write-back step.
// in_chan.ready is high only while the sequencer is idle, so one problem is
// in flight at a time. The result sits in an output register; a new problem
// is taken while it waits, and the next result waits until out_chan.ready.
// Reset (rst_n low, synchronous) returns to idle with no result pending;
// the row banks need no clearing since each entry is written before use.

module egg_drop_min_trials #(
  parameter int MAX_EGGS   = 16,
  parameter int MAX_FLOORS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  edmt_in_if.sink    in_chan,
  edmt_out_if.source out_chan
);
  import edmt_pkg::*;

  localparam int FLOOR_W = $clog2(MAX_FLOORS + 1);
  localparam int EGG_W   = $clog2(MAX_EGGS + 1);
  localparam int ENTRY_W = (FLOOR_W > OUT_W) ? FLOOR_W : OUT_W;
  localparam int ROW_LEN = MAX_FLOORS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_START,
    ST_SCAN,
    ST_DRAIN,
    ST_STORE,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [EGG_W-1:0]   eggs_r;
  logic [EGG_W-1:0]   e_r;
  logic [FLOOR_W-1:0] floors_r;
  logic [FLOOR_W-1:0] f_r;
  logic [FLOOR_W-1:0] x_r;
  logic               bank_r;
  logic               rd_valid_r;
  logic [OUT_W-1:0]   res_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic [EGG_W-1:0]   eggs_sat;
  logic [FLOOR_W-1:0] floors_sat;
  logic               accept;

  logic               wr_en;
  logic               wr_bank;
  logic [FLOOR_W-1:0] wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [FLOOR_W-1:0] prev_addr;
  logic [FLOOR_W-1:0] cur_addr;
  logic [FLOOR_W-1:0] rd_addr0;
  logic [FLOOR_W-1:0] rd_addr1;
  logic [ENTRY_W-1:0] rd_data0;
  logic [ENTRY_W-1:0] rd_data1;
  logic [ENTRY_W-1:0] broke;
  logic [ENTRY_W-1:0] held;
  logic [ENTRY_W-1:0] best;
  edmt_step_ctl_t     step_ctl;

  function automatic logic [OUT_W-1:0] sat_out(input logic [ENTRY_W-1:0] v);
    sat_out = (v > ENTRY_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  // input saturation
  assign eggs_sat   = (int'(in_chan.eggs) > MAX_EGGS) ? EGG_W'(MAX_EGGS)
                                                      : EGG_W'(in_chan.eggs);
  assign floors_sat = (int'(in_chan.floors) > MAX_FLOORS) ? FLOOR_W'(MAX_FLOORS)
                                                          : FLOOR_W'(in_chan.floors);

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && (state_r == ST_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
    end else begin
      rd_valid_r <= (state_r == ST_SCAN);
      if (out_valid_r && out_chan.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            eggs_r   <= eggs_sat;
            floors_r <= floors_sat;
            f_r      <= '0;
            if (floors_sat == '0) begin
              res_r   <= '0;
              state_r <= ST_DONE;
            end else if (eggs_sat == '0) begin
              res_r   <= OUT_MAX;
              state_r <= ST_DONE;
            end else if (eggs_sat == EGG_W'(1)) begin
              res_r   <= sat_out(ENTRY_W'(floors_sat));
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          // one-egg row goes to bank 0
          if (f_r == floors_r) begin
            e_r     <= EGG_W'(2);
            bank_r  <= 1'b1;
            state_r <= ST_ROW_START;
          end else begin
            f_r <= f_r + FLOOR_W'(1);
          end
        end
        ST_ROW_START: begin
          f_r     <= FLOOR_W'(1);
          x_r     <= FLOOR_W'(1);
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (x_r == FLOOR_W'(1)) begin
            state_r <= ST_DRAIN;
          end else begin
            x_r <= x_r - FLOOR_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_STORE;
        end
        ST_STORE: begin
          if (f_r != floors_r) begin
            f_r     <= f_r + FLOOR_W'(1);
            x_r     <= f_r + FLOOR_W'(1);
            state_r <= ST_SCAN;
          end else if (e_r == eggs_r) begin
            res_r   <= sat_out(best);
            state_r <= ST_DONE;
          end else begin
            e_r     <= e_r + EGG_W'(1);
            bank_r  <= ~bank_r;
            state_r <= ST_ROW_START;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.min_trials = out_data_r;

  // table write port decode
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = bank_r;
    wr_addr = f_r;
    wr_data = best;
    unique case (state_r)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_bank = 1'b0;
        wr_data = ENTRY_W'(f_r);
      end
      ST_ROW_START: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '0;
      end
      ST_STORE: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // read addresses: previous row at x-1, current row at f-x
  assign prev_addr = x_r - FLOOR_W'(1);
  assign cur_addr  = f_r - x_r;
  assign rd_addr0  = bank_r ? prev_addr : cur_addr;
  assign rd_addr1  = bank_r ? cur_addr : prev_addr;

  edmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROW_LEN)
  ) u_bank0 (
    .clk     (clk),
    .wr_en   (wr_en && !wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr0),
    .rd_data (rd_data0)
  );

  edmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROW_LEN)
  ) u_bank1 (
    .clk     (clk),
    .wr_en   (wr_en && wr_bank),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr1),
    .rd_data (rd_data1)
  );

  // route bank outputs to the broken-egg and held-egg operands
  assign broke = bank_r ? rd_data0 : rd_data1;
  assign held  = bank_r ? rd_data1 : rd_data0;

  assign step_ctl.clear = (state_r == ST_STORE) || (state_r == ST_ROW_START);
  assign step_ctl.en    = rd_valid_r;

  edmt_step_unit #(
    .ENTRY_W (ENTRY_W)
  ) u_step (
    .clk   (clk),
    .ctl   (step_ctl),
    .broke (broke),
    .held  (held),
    .best  (best)
  );

  // write-back only after the last read has been folded in
  a_store_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE) |-> ($past(state_r) == ST_DRAIN))
    else $error("write-back without drain cycle");

  // drop position stays within 1..f while scanning
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((x_r != '0) && (x_r <= f_r) && (f_r <= floors_r)))
    else $error("drop position out of range");

  // row counter never passes the egg count
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_START) |-> ((e_r <= eggs_r) && (e_r >= EGG_W'(2))))
    else $error("egg row out of range");

  // minimum never rises above the sentinel once rows of two or more eggs run
  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STORE) |-> (best <= ENTRY_W'(OUT_MAX)))
    else $error("running minimum above sentinel");

  // no read data is folded in while the minimum is being reloaded
  a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(step_ctl.clear && step_ctl.en))
    else $error("step unit clear and fold in the same cycle");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for egg_drop_min_trials, directed table then random problems
// depends on edmt_pkg, edmt_if and the egg_drop_min_trials design files

module tb_top;
  import edmt_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int MAX_EGGS       = 16;
  localparam int MAX_FLOORS     = 256;
  localparam int RAND_PER_PHASE = 20;
  localparam int NUM_PHASES     = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 6000000;
  localparam int NUM_DIRECTED   = 22;

  // one row of the directed table; the answer is used only when typed is set
  typedef struct packed {
    logic [EGGS_IN_W-1:0]   eggs;
    logic [FLOORS_IN_W-1:0] floors;
    logic                   typed;
    logic [OUT_W-1:0]       answer;
  } drop_case_t;

  logic clk;
  logic rst_n;

  edmt_in_if  in_if ();
  edmt_out_if out_if ();

  egg_drop_min_trials #(
    .MAX_EGGS  (MAX_EGGS),
    .MAX_FLOORS(MAX_FLOORS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // scratch table of the predictor
  int drops_tbl [0:MAX_EGGS][0:MAX_FLOORS];

  // answers still owed by the block, oldest first
  logic [OUT_W-1:0] trials_due [$];

  int fail_cnt  = 0;
  int idle_pct  = 0;
  int stall_pct = 0;

  // directed problems: extremes, zero eggs, zero floors, saturation, classic answers
  drop_case_t dir_cases [NUM_DIRECTED] = '{
    '{5'd1,  9'd0,   1'b1, 9'd0},
    '{5'd0,  9'd0,   1'b1, 9'd0},
    '{5'd31, 9'd0,   1'b1, 9'd0},
    '{5'd0,  9'd1,   1'b1, OUT_MAX},
    '{5'd0,  9'd511, 1'b1, OUT_MAX},
    '{5'd1,  9'd1,   1'b1, 9'd1},
    '{5'd1,  9'd256, 1'b1, 9'd256},
    '{5'd1,  9'd511, 1'b1, 9'd256},
    '{5'd1,  9'd300, 1'b1, 9'd256},
    '{5'd2,  9'd1,   1'b1, 9'd1},
    '{5'd2,  9'd10,  1'b1, 9'd4},
    '{5'd2,  9'd36,  1'b1, 9'd8},
    '{5'd2,  9'd100, 1'b1, 9'd14},
    '{5'd3,  9'd14,  1'b1, 9'd4},
    '{5'd16, 9'd1,   1'b1, 9'd1},
    '{5'd16, 9'd8,   1'b1, 9'd4},
    '{5'd17, 9'd5,   1'b0, 9'd0},
    '{5'd2,  9'd256, 1'b0, 9'd0},
    '{5'd5,  9'd7,   1'b0, 9'd0},
    '{5'd4,  9'd30,  1'b0, 9'd0},
    '{5'd10, 9'd2,   1'b0, 9'd0},
    '{5'd31, 9'd511, 1'b1, 9'd9}
  };

  // clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // fill the drop table up to the clamped size and read off the answer
  function automatic logic [OUT_W-1:0] predict_min_drops(
    input logic [EGGS_IN_W-1:0]   eggs_in,
    input logic [FLOORS_IN_W-1:0] floors_in
  );
    int egg_lim;
    int floor_lim;
    int worst;
    int best;
    egg_lim   = (eggs_in > MAX_EGGS) ? MAX_EGGS : int'(eggs_in);
    floor_lim = (floors_in > MAX_FLOORS) ? MAX_FLOORS : int'(floors_in);
    if (floor_lim == 0) return '0;
    if (egg_lim == 0) return OUT_MAX;
    for (int e = 0; e <= egg_lim; e++) drops_tbl[e][0] = 0;
    for (int f = 0; f <= floor_lim; f++) begin
      drops_tbl[0][f] = 0;
      drops_tbl[1][f] = f;
    end
    for (int e = 2; e <= egg_lim; e++) begin
      for (int f = 1; f <= floor_lim; f++) begin
        best = int'(OUT_MAX);
        for (int x = 1; x <= f; x++) begin
          worst = (drops_tbl[e-1][x-1] > drops_tbl[e][f-x]) ?
                  drops_tbl[e-1][x-1] : drops_tbl[e][f-x];
          if (worst + 1 < best) best = worst + 1;
        end
        drops_tbl[e][f] = best;
      end
    end
    best = drops_tbl[egg_lim][floor_lim];
    return (best > int'(OUT_MAX)) ? OUT_MAX : best[OUT_W-1:0];
  endfunction

  // drive one problem; entered and left at a falling edge, valid stays up on exit
  task automatic send_problem(
    input logic [EGGS_IN_W-1:0]   eggs_v,
    input logic [FLOORS_IN_W-1:0] floors_v,
    input logic                   typed,
    input logic [OUT_W-1:0]       answer
  );
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid  = 1'b1;
    in_if.eggs   = eggs_v;
    in_if.floors = floors_v;
    do @(posedge clk); while (!in_if.ready);
    // transaction accepted, queue its answer
    if (typed) trials_due.push_back(answer);
    else trials_due.push_back(predict_min_drops(eggs_v, floors_v));
    @(negedge clk);
  endtask

  // random problem: mostly well-formed small sizes, some corners and wide floor codes
  task automatic pick_problem(
    output logic [EGGS_IN_W-1:0]   eggs_v,
    output logic [FLOORS_IN_W-1:0] floors_v
  );
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      eggs_v   = EGGS_IN_W'($urandom_range(MAX_EGGS, 1));
      floors_v = FLOORS_IN_W'($urandom_range(20, 1));
    end else if (sel < 80) begin
      eggs_v   = EGGS_IN_W'($urandom_range(3, 1));
      floors_v = FLOORS_IN_W'($urandom_range(60, 21));
    end else if (sel < 85) begin
      eggs_v   = EGGS_IN_W'($urandom_range(31, MAX_EGGS + 1));
      floors_v = FLOORS_IN_W'($urandom_range(12, 1));
    end else if (sel < 90) begin
      eggs_v   = EGGS_IN_W'($urandom_range(31));
      floors_v = '0;
    end else if (sel < 95) begin
      eggs_v   = '0;
      floors_v = FLOORS_IN_W'($urandom_range(511));
    end else begin
      eggs_v   = 5'd1;
      floors_v = FLOORS_IN_W'($urandom_range(511, MAX_FLOORS));
    end
  endtask

  // result side stall pattern, changed at the falling edge
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result transaction with the oldest queued answer
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (trials_due.size() == 0) begin
        $error("min_trials: no transaction pending, actual %0d", out_if.min_trials);
        fail_cnt++;
      end else begin
        if (out_if.min_trials !== trials_due[0]) begin
          $error("min_trials: expected %0d, actual %0d", trials_due[0], out_if.min_trials);
          fail_cnt++;
        end
        void'(trials_due.pop_front());
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [EGGS_IN_W-1:0]   eggs_r;
    logic [FLOORS_IN_W-1:0] floors_r;
    in_if.valid  = 1'b0;
    in_if.eggs   = '0;
    in_if.floors = '0;
    rst_n        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table with no idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_problem(dir_cases[i].eggs, dir_cases[i].floors,
                   dir_cases[i].typed, dir_cases[i].answer);
    end

    // random phases: free flow, idle sender, stalling receiver, both
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        pick_problem(eggs_r, floors_r);
        send_problem(eggs_r, floors_r, 1'b0, '0);
      end
    end
    in_if.valid = 1'b0;

    // drain outstanding answers, then a short settle
    while (trials_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[egg_drop_min_trials] OK");
    end else begin
      $display("[egg_drop_min_trials] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[egg_drop_min_trials] ERROR");
    $finish;
  end

endmodule
